### sv/ict_pkg.sv
// Package for the interval coalescing tracker: request/response payload types
// and shared constants. No dependencies.
`default_nettype none
package ict_pkg;
   localparam int MaxRangesDefault = 16;
   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] offset;
      logic [31:0] length;
   } req_type_type;

   typedef struct packed {
      logic       overlap_found;
      logic       all_received;
      logic       table_full;
      logic [4:0] range_count;
   } rsp_type;
endpackage
`default_nettype wire

### sv/interval_coalescing_tracker.sv
// Interval coalescing tracker top level: sorted range table in two synchronous memories
// (start/end), scanned, compacted and shifted in place by one sequencer. Depends on ict_pkg.
// One request in flight; req_ready returns the cycle after the response transfer. Clear, zero-length
// add and type 3 go straight to the response; query and dropped add scan the table once; add scans,
// compacts, shifts entries up and inserts. Sync reset clears count, total_size, sequencer; memory
// undefined.
`default_nettype none
module interval_coalescing_tracker #(
   parameter int MAX_RANGES = ict_pkg::MaxRangesDefault
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  ict_pkg::req_type_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output ict_pkg::rsp_type     rsp_data,
   input  wire                  csr_we,
   input  wire [63:0]           csr_wdata
);
   localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam logic [63:0] ONES = '1;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_COMPACT, S_SHIFT_RD, S_SHIFT_WR, S_INSERT, S_READ0, S_RESULT, S_RSP
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] count_ff, idx_ff, wr_ff;
   logic [63:0]   total_ff, a_ff, b_ff;
   logic [1:0]    op_ff;
   logic          hit_ff, full_ff, rd_ok_ff;
   ict_pkg::rsp_type rsp_ff;

   logic [63:0] mem_s [MAX_RANGES];
   logic [63:0] mem_e [MAX_RANGES];
   logic [63:0] rs_ff, re_ff;

   // one write and one read a cycle on each memory
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [63:0]   ws, wv;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_s[waddr] <= ws;
         mem_e[waddr] <= wv;
      end
      rs_ff <= mem_s[raddr];
      re_ff <= mem_e[raddr];
   end

   logic touch, inside_q, scan_hit, keep;
   always_comb begin
      touch = ((rs_ff == 64'd0) || (rs_ff - 64'd1 <= b_ff)) &&
              ((a_ff == 64'd0) || (re_ff >= a_ff - 64'd1));
      inside_q = (rs_ff <= b_ff) && (re_ff >= a_ff);
      scan_hit = (op_ff == ict_pkg::REQ_ADD) ? touch : inside_q;
      keep = rd_ok_ff && !touch;
   end

   logic [63:0] end_in;
   logic [64:0] sum;
   always_comb begin
      sum = {1'b0, req_data.offset} + {33'd0, req_data.length} - 65'd1;
      if (req_data.length == 32'd0) end_in = req_data.offset;
      else if (sum[64]) end_in = ONES;
      else end_in = sum[63:0];
   end

   // entry 0 is on rs_ff/re_ff in S_RESULT
   logic complete;
   always_comb begin
      if (total_ff == 64'd0) complete = 1'b1;
      else if (count_ff != CW'(1) || rs_ff != 64'd0) complete = 1'b0;
      else complete = (re_ff == ONES) || (re_ff + 64'd1 >= total_ff);
   end

   always_comb begin
      we = 1'b0; waddr = idx_ff[AW-1:0]; ws = a_ff; wv = b_ff;
      raddr = idx_ff[AW-1:0];
      case (state_ff)
         S_COMPACT: begin
            if (keep) begin
               we = 1'b1; waddr = wr_ff[AW-1:0]; ws = rs_ff; wv = re_ff;
            end
         end
         S_SHIFT_RD: begin
            raddr = AW'(idx_ff - CW'(1));
         end
         S_SHIFT_WR: begin
            // rs_ff holds entry idx-1; move it up unless the new range goes here
            if (rs_ff >= a_ff) begin
               we = 1'b1; ws = rs_ff; wv = re_ff;
            end
         end
         S_INSERT: begin
            we = 1'b1;
         end
         S_READ0: begin
            raddr = '0;
         end
         default: ;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         if (csr_we) total_ff <= csr_wdata;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  op_ff <= req_data.req_type;
                  a_ff <= req_data.offset;
                  b_ff <= end_in;
                  hit_ff <= 1'b0; full_ff <= 1'b0;
                  idx_ff <= '0; wr_ff <= '0; rd_ok_ff <= 1'b0;
                  if (req_data.req_type == ict_pkg::REQ_CLEAR) begin
                     count_ff <= '0;
                     state_ff <= S_READ0;
                  end else if (req_data.req_type == ict_pkg::REQ_QUERY ||
                               (req_data.req_type == ict_pkg::REQ_ADD &&
                                req_data.length != 32'd0)) begin
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_READ0;
                  end
               end
            end
            S_SCAN: begin
               // pass 1: any touching range (add) or overlap (query)
               if (rd_ok_ff) hit_ff <= hit_ff | scan_hit;
               if (idx_ff < count_ff) begin
                  idx_ff <= idx_ff + CW'(1); rd_ok_ff <= 1'b1;
               end else begin
                  rd_ok_ff <= 1'b0;
                  idx_ff <= '0;
                  if (op_ff != ict_pkg::REQ_ADD) begin
                     state_ff <= S_READ0;
                  end else if (!hit_ff && !(rd_ok_ff && touch) &&
                               count_ff >= CW'(MAX_RANGES)) begin
                     full_ff <= 1'b1;
                     state_ff <= S_READ0;
                  end else begin
                     state_ff <= S_COMPACT;
                  end
               end
            end
            S_COMPACT: begin
               // pass 2: fold touching ranges into [a,b], keep the rest packed
               if (rd_ok_ff && touch) begin
                  if (rs_ff < a_ff) a_ff <= rs_ff;
                  if (re_ff > b_ff) b_ff <= re_ff;
               end
               if (idx_ff < count_ff) begin
                  if (keep) wr_ff <= wr_ff + CW'(1);
                  idx_ff <= idx_ff + CW'(1); rd_ok_ff <= 1'b1;
               end else begin
                  rd_ok_ff <= 1'b0;
                  idx_ff <= keep ? wr_ff + CW'(1) : wr_ff;
                  count_ff <= keep ? wr_ff + CW'(1) : wr_ff;
                  state_ff <= S_SHIFT_RD;
               end
            end
            S_SHIFT_RD: begin
               // idx_ff is the free slot, walking down from the top
               if (idx_ff == '0) state_ff <= S_INSERT;
               else state_ff <= S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
               if (rs_ff < a_ff) begin
                  state_ff <= S_INSERT;
               end else begin
                  idx_ff <= idx_ff - CW'(1);
                  state_ff <= S_SHIFT_RD;
               end
            end
            S_INSERT: begin
               count_ff <= count_ff + CW'(1);
               state_ff <= S_READ0;
            end
            S_READ0: begin
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               rsp_ff.overlap_found <= (op_ff == ict_pkg::REQ_QUERY) && hit_ff;
               rsp_ff.all_received  <= complete;
               rsp_ff.table_full    <= full_ff;
               rsp_ff.range_count   <= 5'(count_ff);
               state_ff <= S_RSP;
            end
            S_RSP: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
